// ----- sv/atfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfb_pkg: shared types and constants of the transmit frame builder
// Holds the frame constants, register indexes, register reset values and the
// structures passed between the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
package atfb_pkg;

  // Frame constants.
  localparam logic [7:0] DELIM_BYTE  = 8'h7E;
  localparam logic [7:0] FRAME_TYPE  = 8'h10;
  localparam logic [7:0] CKSUM_BASE  = 8'hFF;
  localparam logic [8:0] FIXED_LEN   = 9'd14;
  localparam logic [8:0] MAX_PAYLOAD = 9'd256;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR_1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR_2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR_3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_IDENT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DEST  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TX_OPTIONS  = 4'd7;

  // Register reset values.
  localparam logic [63:0] DEST_ADDR_RST   = 64'h0013_A200_41F1_D3D7;
  localparam logic [7:0]  FRAME_IDENT_RST = 8'h01;
  localparam logic [15:0] SHORT_DEST_RST  = 16'hFFFE;
  localparam logic [7:0]  RADIUS_RST      = 8'h00;
  localparam logic [7:0]  TX_OPTIONS_RST  = 8'h00;

  // Item queue depth.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register set.
  typedef struct packed {
    logic [63:0] dest_addr_0;
    logic [63:0] dest_addr_1;
    logic [63:0] dest_addr_2;
    logic [63:0] dest_addr_3;
    logic [7:0]  frame_ident;
    logic [15:0] short_dest;
    logic [7:0]  radius;
    logic [7:0]  tx_options;
  } cfg_t;

  // One classified item as handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [8:0] length;
    logic [1:0] destination;
    logic       first;
    logic       last;
  } item_t;

endpackage

// ----- sv/api_transmit_frame_builder.sv -----
`timescale 1ns / 1ps
// An accepted item passes through the item queue before its first result is registered.
// One result byte per cycle while the queue holds an item and results are popped. The first
// byte of a frame is sent as 17 header bytes and the payload byte, then the checksum if it is
// last. Other bytes go out alone, then the checksum if last. A two-entry queue buffers items.
// Reset: synchronous, active high; clears frame state and loads register defaults.
// ----------------------------------------------------------------------------
// api_transmit_frame_builder: transmit-request frame serializer
// Accepts payload bytes, prepends the frame header on the first byte of a frame
// and appends the checksum after the last one.
// ----------------------------------------------------------------------------
module api_transmit_frame_builder
  import atfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input item queue side.
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           payload_byte,
  input  logic [8:0]           payload_length,
  input  logic [1:0]           destination,
  // Result queue side.
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 frame_end,
  output logic                 run_last,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_t  cfg;
  item_t front_item;
  item_t head_item;
  logic  accept;
  logic  q_empty;
  logic  head_done;
  logic  out_valid;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign empty     = !out_valid;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_addr_0 <= DEST_ADDR_RST;
      cfg.dest_addr_1 <= DEST_ADDR_RST;
      cfg.dest_addr_2 <= DEST_ADDR_RST;
      cfg.dest_addr_3 <= DEST_ADDR_RST;
      cfg.frame_ident <= FRAME_IDENT_RST;
      cfg.short_dest  <= SHORT_DEST_RST;
      cfg.radius      <= RADIUS_RST;
      cfg.tx_options  <= TX_OPTIONS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_ADDR_0: cfg.dest_addr_0 <= cfg_data;
        REG_DEST_ADDR_1: cfg.dest_addr_1 <= cfg_data;
        REG_DEST_ADDR_2: cfg.dest_addr_2 <= cfg_data;
        REG_DEST_ADDR_3: cfg.dest_addr_3 <= cfg_data;
        REG_FRAME_IDENT: cfg.frame_ident <= cfg_data[7:0];
        REG_SHORT_DEST:  cfg.short_dest  <= cfg_data[15:0];
        REG_RADIUS:      cfg.radius      <= cfg_data[7:0];
        REG_TX_OPTIONS:  cfg.tx_options  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: classify accepted items.
  atfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .destination    (destination),
    .item           (front_item)
  );

  // Queue between the two halves.
  atfb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_item (front_item),
    .rd_en   (head_done),
    .rd_item (head_item),
    .full    (full),
    .empty   (q_empty)
  );

  // Back end: serialize header, payload and checksum.
  atfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head_item),
    .head_valid (!q_empty),
    .head_done  (head_done),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

endmodule

// ----- sv/atfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfb_front: input classifier
// Tracks frame position, clamps the payload length on the first byte and tags
// each accepted item as first and/or last byte of its frame.
// ----------------------------------------------------------------------------
module atfb_front
  import atfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] payload_byte,
  input  logic [8:0] payload_length,
  input  logic [1:0] destination,
  output item_t      item
);

  logic       in_frame;
  logic [8:0] bytes_left;
  logic [8:0] len_clamped;

  // Zero length counts as one byte, oversize saturates.
  always_comb begin
    len_clamped = payload_length;
    if (payload_length == 9'd0) begin
      len_clamped = 9'd1;
    end else if (payload_length > MAX_PAYLOAD) begin
      len_clamped = MAX_PAYLOAD;
    end
  end

  // Classification of the incoming item.
  always_comb begin
    item.payload_byte = payload_byte;
    item.length       = len_clamped;
    item.destination  = destination;
    item.first        = !in_frame;
    item.last         = in_frame ? (bytes_left == 9'd1) : (len_clamped == 9'd1);
  end

  // Frame position tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 9'd0;
    end else if (accept) begin
      if (!in_frame) begin
        bytes_left <= len_clamped - 9'd1;
        in_frame   <= (len_clamped != 9'd1);
      end else begin
        bytes_left <= bytes_left - 9'd1;
        in_frame   <= (bytes_left != 9'd1);
      end
    end
  end

endmodule

// ----- sv/atfb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfb_queue: item queue
// Short first-in first-out buffer that decouples the classifier from the
// byte sequencer.
// ----------------------------------------------------------------------------
module atfb_queue
  import atfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/atfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfb_back: byte sequencer
// Walks the header, payload and checksum steps of the item at the queue head
// and, while the output register is free, emits one byte per cycle into it.
// ----------------------------------------------------------------------------
module atfb_back
  import atfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  item_t      head,
  input  logic       head_valid,
  output logic       head_done,
  input  logic       pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       run_last
);

  // Sequencer step codes.
  localparam logic [4:0] STEP_DELIM    = 5'd0;
  localparam logic [4:0] STEP_LEN_HI   = 5'd1;
  localparam logic [4:0] STEP_LEN_LO   = 5'd2;
  localparam logic [4:0] STEP_TYPE     = 5'd3;
  localparam logic [4:0] STEP_IDENT    = 5'd4;
  localparam logic [4:0] STEP_ADDR_7   = 5'd5;
  localparam logic [4:0] STEP_ADDR_6   = 5'd6;
  localparam logic [4:0] STEP_ADDR_5   = 5'd7;
  localparam logic [4:0] STEP_ADDR_4   = 5'd8;
  localparam logic [4:0] STEP_ADDR_3   = 5'd9;
  localparam logic [4:0] STEP_ADDR_2   = 5'd10;
  localparam logic [4:0] STEP_ADDR_1   = 5'd11;
  localparam logic [4:0] STEP_ADDR_0   = 5'd12;
  localparam logic [4:0] STEP_SDEST_HI = 5'd13;
  localparam logic [4:0] STEP_SDEST_LO = 5'd14;
  localparam logic [4:0] STEP_RADIUS   = 5'd15;
  localparam logic [4:0] STEP_OPTIONS  = 5'd16;
  localparam logic [4:0] STEP_PAYLOAD  = 5'd17;
  localparam logic [4:0] STEP_CHECKSUM = 5'd18;

  logic [4:0]  step;
  logic [4:0]  cur_step;
  logic [7:0]  running_sum;
  logic [63:0] addr_sel;
  logic [8:0]  total_len;
  logic [7:0]  byte_sel;
  logic        summed;
  logic        fire;
  logic        is_check;

  // A continuation byte skips the header steps.
  assign cur_step  = (!head.first && step == STEP_DELIM) ? STEP_PAYLOAD : step;
  assign fire      = head_valid && (!out_valid || pop);
  assign is_check  = (cur_step == STEP_CHECKSUM);
  assign head_done = fire && (is_check || (cur_step == STEP_PAYLOAD && !head.last));
  assign total_len = FIXED_LEN + head.length;

  // Destination address selection.
  always_comb begin
    case (head.destination)
      2'd0:    addr_sel = cfg.dest_addr_0;
      2'd1:    addr_sel = cfg.dest_addr_1;
      2'd2:    addr_sel = cfg.dest_addr_2;
      default: addr_sel = cfg.dest_addr_3;
    endcase
  end

  // Byte for the current step and whether it enters the checksum.
  always_comb begin
    summed = 1'b1;
    case (cur_step)
      STEP_DELIM: begin
        byte_sel = DELIM_BYTE;
        summed   = 1'b0;
      end
      STEP_LEN_HI: begin
        byte_sel = {7'd0, total_len[8]};
        summed   = 1'b0;
      end
      STEP_LEN_LO: begin
        byte_sel = total_len[7:0];
        summed   = 1'b0;
      end
      STEP_TYPE:     byte_sel = FRAME_TYPE;
      STEP_IDENT:    byte_sel = cfg.frame_ident;
      STEP_ADDR_7:   byte_sel = addr_sel[63:56];
      STEP_ADDR_6:   byte_sel = addr_sel[55:48];
      STEP_ADDR_5:   byte_sel = addr_sel[47:40];
      STEP_ADDR_4:   byte_sel = addr_sel[39:32];
      STEP_ADDR_3:   byte_sel = addr_sel[31:24];
      STEP_ADDR_2:   byte_sel = addr_sel[23:16];
      STEP_ADDR_1:   byte_sel = addr_sel[15:8];
      STEP_ADDR_0:   byte_sel = addr_sel[7:0];
      STEP_SDEST_HI: byte_sel = cfg.short_dest[15:8];
      STEP_SDEST_LO: byte_sel = cfg.short_dest[7:0];
      STEP_RADIUS:   byte_sel = cfg.radius;
      STEP_OPTIONS:  byte_sel = cfg.tx_options;
      STEP_PAYLOAD:  byte_sel = head.payload_byte;
      STEP_CHECKSUM: begin
        byte_sel = CKSUM_BASE - running_sum;
        summed   = 1'b0;
      end
      default: begin
        byte_sel = head.payload_byte;
        summed   = 1'b0;
      end
    endcase
  end

  // Step counter and checksum accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_DELIM;
      running_sum <= 8'd0;
    end else if (fire) begin
      if (head_done) begin
        step <= STEP_DELIM;
      end else begin
        step <= cur_step + 5'd1;
      end
      if (cur_step == STEP_DELIM || is_check) begin
        running_sum <= 8'd0;
      end else if (summed) begin
        running_sum <= running_sum + byte_sel;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= byte_sel;
      frame_end <= is_check;
      run_last  <= head_done;
    end
  end

endmodule
